// ===== rtl/core/rgb_kernel_convolution_core_defines.svh =====
// assertion macros for the rgb kernel convolution core
// used by rgb_kernel_convolution_core.sv; expects clk and rst in scope
`ifndef RGB_KERNEL_CONVOLUTION_CORE_DEFINES_SVH
`define RGB_KERNEL_CONVOLUTION_CORE_DEFINES_SVH

// same-cycle implication
`define RKC_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RKC_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rkc_pkg.sv =====
// shared constants for the rgb kernel convolution core
// no dependencies
package rkc_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_KERNEL = 5;

  localparam int PIX_W      = 8;
  localparam int COEF_W     = 8;
  localparam int FUNC_W     = 2;
  localparam int CIDX_W     = 5;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int SIZE_REG_W = 11;
  localparam int KSIZE_REG_W = 3;

  localparam logic [SIZE_REG_W-1:0]  RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [SIZE_REG_W-1:0]  RST_IMAGE_HEIGHT = 11'd480;
  localparam logic [KSIZE_REG_W-1:0] RST_KERNEL_SIZE  = 3'd3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE    = 2'd3;

  localparam logic [FUNC_W-1:0] FUNC_COEF  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PIXEL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DRAIN = 2'd2;

  localparam int PIX_MAX = 255;

endpackage

// ===== rtl/core/rgb_kernel_convolution_core.sv =====
// rgb kernel convolution core: top level, sequencer, line store and serial divider
// depends on rkc_pkg and rgb_kernel_convolution_core_defines.svh
//
// channel   dir  handshake            payload
// s_*       in   s_tvalid / s_tready  s_tdata, s_tuser = func
// m_*       out  m_tvalid / m_tready  m_tdata, m_tlast = frame_end
// cfg_*     in   cfg_we               cfg_index, cfg_data
//
// an output pixel, from a pixel or a drain request, takes K*K taps
// (none when K is zero), one tap per line store read
// normalize adds 3 serial divisions of an N-bit dividend, N = divider width (22 by default)
// after a width write the first output adds 2 more divisions to find its position
// rst is synchronous; the input is not ready while a request is in work
// a waiting output holds the sequencer only when the next result is due
`include "rgb_kernel_convolution_core_defines.svh"
module rgb_kernel_convolution_core #(
  parameter int MAX_WIDTH  = rkc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rkc_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_KERNEL = rkc_pkg::DEF_MAX_KERNEL
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [rkc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rkc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic s_tvalid,
  output logic s_tready,
  // coef_index, coef_value, red_in, green_in, blue_in, zero fill
  input  logic [rkc_pkg::S_TDATA_W-1:0] s_tdata,
  // func
  input  logic [rkc_pkg::FUNC_W-1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // red_out, green_out, blue_out
  output logic [rkc_pkg::M_TDATA_W-1:0] m_tdata,
  output logic m_tlast
);
  import rkc_pkg::*;

  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int IW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int KW   = $clog2(MAX_KERNEL + 1);
  localparam int TD   = MAX_KERNEL * MAX_KERNEL;
  localparam int CIW  = (TD > 1) ? $clog2(TD) : 1;
  localparam int SLW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int SD   = MAX_KERNEL * MAX_WIDTH;
  localparam int SAW  = $clog2(SD);
  localparam int PW   = PIX_W + 1 + COEF_W;
  localparam int SUMW = PW + $clog2(TD);
  localparam int AW   = COEF_W + $clog2(TD) + 1;
  localparam int CW   = IW + KW + 2;
  localparam int YW   = HW + 2;
  localparam int XSW  = WW + 2;
  localparam int DN0  = (IW > SUMW) ? IW : SUMW;
  localparam int DN   = (DN0 > HW) ? DN0 : HW;
  localparam int DD0  = (WW > AW) ? WW : AW;
  localparam int DD   = (DD0 > KW) ? DD0 : KW;
  localparam int DCW  = $clog2(DN);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_CHECK, S_EMIT, S_DIV, S_DIV_DONE,
    S_TAP_INIT, S_TAP, S_TAP_FLUSH, S_NORM, S_FINISH
  } state_t;

  typedef enum logic [1:0] {DU_COL, DU_ROW, DU_CH} div_use_t;

  state_t state;
  div_use_t div_use;

  logic [SIZE_REG_W-1:0]  reg_width, reg_height;
  logic [KSIZE_REG_W-1:0] reg_ksize;
  logic                   reg_norm;

  logic signed [COEF_W-1:0] kernel_table [TD];
  logic [3*PIX_W-1:0] line_store [SD];
  logic [3*PIX_W-1:0] rd_data;

  logic [FUNC_W-1:0] it_func;
  logic [CIDX_W-1:0] it_cidx;
  logic signed [COEF_W-1:0] it_cval;
  logic [3*PIX_W-1:0] it_pix;

  logic [XW-1:0]  in_col, out_col, col_eff;
  logic [HW-1:0]  in_row, out_row;
  logic [SLW-1:0] in_slot, out_slot, t_slot;
  logic [IW-1:0]  out_index, n_reg, total;
  logic [CW-1:0]  lag_reg;
  logic           pos_dirty;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [KW-1:0] k_eff, back, fwd;

  logic [KW-1:0]  ta, tb;
  logic [CIW-1:0] t_ci;
  logic           tap_v;
  logic signed [COEF_W-1:0] tap_coef;
  logic signed [YW-1:0]  ty;
  logic signed [XSW-1:0] tx;
  logic inb;
  logic [SAW-1:0] rd_addr, wr_addr;
  logic store_we;

  logic signed [SUMW-1:0] acc [3];
  logic signed [AW-1:0]   alpha;
  logic signed [PW-1:0]   prod_r, prod_g, prod_b;
  logic [1:0] ch, ch_sel;
  logic signed [SUMW-1:0] acc_sel;
  logic [SUMW-1:0] acc_mag;
  logic [AW-1:0]   alpha_mag;

  logic [DN-1:0]  div_quo, quo_next;
  logic [DD-1:0]  div_rem, div_den, rem_next;
  logic [DD:0]    rs;
  logic           ge;
  logic [DCW-1:0] div_cnt;
  logic           div_neg;

  function automatic logic [PIX_W-1:0] clamp8(input logic signed [SUMW-1:0] v);
    if (v < 0) return '0;
    if (v > $signed(SUMW'(PIX_MAX))) return PIX_W'(PIX_MAX);
    return v[PIX_W-1:0];
  endfunction

  // effective geometry
  always_comb begin
    if (reg_width == '0) w_eff = WW'(1);
    else if (32'(reg_width) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(reg_width);
    if (reg_height == '0) h_eff = HW'(1);
    else if (32'(reg_height) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(reg_height);
    if (32'(reg_ksize) > MAX_KERNEL) k_eff = KW'(MAX_KERNEL);
    else k_eff = KW'(reg_ksize);
    back = k_eff >> 1;
    if (k_eff == '0) fwd = '0;
    else if (k_eff[0]) fwd = k_eff >> 1;
    else fwd = (k_eff >> 1) - 1'b1;
  end

  assign total   = IW'(w_eff) * IW'(h_eff);
  assign col_eff = (32'(in_col) >= 32'(w_eff)) ? XW'(w_eff - 1'b1) : in_col;

  // tap position
  assign ty  = $signed(YW'(out_row)) + $signed(YW'(ta)) - $signed(YW'(back));
  assign tx  = $signed(XSW'(out_col)) + $signed(XSW'(tb)) - $signed(XSW'(back));
  assign inb = (ty >= 0) && (ty < $signed(YW'(h_eff))) &&
               (tx >= 0) && (tx < $signed(XSW'(w_eff)));
  assign rd_addr  = SAW'(t_slot) * SAW'(MAX_WIDTH) + SAW'(tx[XW-1:0]);
  assign wr_addr  = SAW'(in_slot) * SAW'(MAX_WIDTH) + SAW'(col_eff);
  assign store_we = (state == S_DECODE) && (it_func == FUNC_PIXEL) && (in_row < h_eff);

  assign prod_r = $signed({1'b0, rd_data[PIX_W-1:0]}) * tap_coef;
  assign prod_g = $signed({1'b0, rd_data[2*PIX_W-1:PIX_W]}) * tap_coef;
  assign prod_b = $signed({1'b0, rd_data[3*PIX_W-1:2*PIX_W]}) * tap_coef;

  // channel feeding the divider
  assign ch_sel    = (state == S_NORM) ? 2'd0 : ch + 2'd1;
  assign acc_sel   = acc[ch_sel];
  assign acc_mag   = (acc_sel < 0) ? SUMW'(-acc_sel) : SUMW'(acc_sel);
  assign alpha_mag = (alpha < 0) ? AW'(-alpha) : AW'(alpha);

  // restoring divider step
  assign rs       = {div_rem, div_quo[DN-1]};
  assign ge       = rs >= {1'b0, div_den};
  assign rem_next = ge ? DD'(rs - {1'b0, div_den}) : DD'(rs);
  assign quo_next = {div_quo[DN-2:0], ge};

  assign s_tready = (state == S_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_width  <= RST_IMAGE_WIDTH;
      reg_height <= RST_IMAGE_HEIGHT;
      reg_ksize  <= RST_KERNEL_SIZE;
      reg_norm   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  reg_width  <= cfg_data;
        REG_IMAGE_HEIGHT: reg_height <= cfg_data;
        REG_KERNEL_SIZE:  reg_ksize  <= cfg_data[KSIZE_REG_W-1:0];
        REG_NORMALIZE:    reg_norm   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // coefficient table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TD; i++) kernel_table[i] <= '0;
    end else if (state == S_DECODE && it_func == FUNC_COEF && 32'(it_cidx) < TD) begin
      kernel_table[CIW'(it_cidx)] <= it_cval;
    end
  end

  // line store
  always_ff @(posedge clk) begin
    if (store_we) line_store[wr_addr] <= it_pix;
    rd_data <= line_store[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_use   <= DU_COL;
      in_col    <= '0;
      in_row    <= '0;
      in_slot   <= '0;
      out_index <= '0;
      out_col   <= '0;
      out_row   <= '0;
      out_slot  <= '0;
      pos_dirty <= 1'b0;
      tap_v     <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_FINISH) m_tvalid <= 1'b0;
      if (tap_v) begin
        acc[0] <= acc[0] + SUMW'(prod_r);
        acc[1] <= acc[1] + SUMW'(prod_g);
        acc[2] <= acc[2] + SUMW'(prod_b);
        alpha  <= alpha + AW'(tap_coef);
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            it_func <= s_tuser;
            it_cidx <= s_tdata[CIDX_W-1:0];
            it_cval <= s_tdata[CIDX_W+COEF_W-1:CIDX_W];
            it_pix  <= s_tdata[CIDX_W+COEF_W+3*PIX_W-1:CIDX_W+COEF_W];
            state   <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (it_func)
            FUNC_PIXEL: begin
              if (in_row < h_eff) begin
                n_reg   <= IW'(in_row) * IW'(w_eff) + IW'(col_eff);
                lag_reg <= CW'(fwd) * (CW'(w_eff) + CW'(1));
                if (32'(col_eff) + 1 >= 32'(w_eff)) begin
                  in_col  <= '0;
                  in_row  <= in_row + 1'b1;
                  in_slot <= (32'(in_slot) == MAX_KERNEL - 1) ? '0 : in_slot + 1'b1;
                end else begin
                  in_col <= col_eff + 1'b1;
                end
                state <= S_CHECK;
              end else begin
                state <= S_IDLE;
              end
            end
            FUNC_DRAIN: begin
              if (in_row >= h_eff) begin
                if (out_index >= total) begin
                  in_col    <= '0;
                  in_row    <= '0;
                  in_slot   <= '0;
                  out_index <= '0;
                  out_col   <= '0;
                  out_row   <= '0;
                  out_slot  <= '0;
                  state     <= S_IDLE;
                end else begin
                  state <= S_EMIT;
                end
              end else begin
                state <= S_IDLE;
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        S_CHECK: begin
          if (out_index < total && CW'(n_reg) + CW'(1) > CW'(out_index) + lag_reg)
            state <= S_EMIT;
          else
            state <= S_IDLE;
        end
        S_EMIT: begin
          if (pos_dirty) begin
            div_quo <= DN'(out_index);
            div_rem <= '0;
            div_den <= DD'(w_eff);
            div_cnt <= DCW'(DN - 1);
            div_use <= DU_COL;
            state   <= S_DIV;
          end else begin
            state <= S_TAP_INIT;
          end
        end
        S_DIV: begin
          div_quo <= quo_next;
          div_rem <= rem_next;
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == '0) state <= S_DIV_DONE;
        end
        S_DIV_DONE: begin
          case (div_use)
            DU_COL: begin
              out_col <= XW'(div_rem);
              out_row <= HW'(div_quo);
              div_quo <= DN'(HW'(div_quo));
              div_rem <= '0;
              div_den <= DD'(MAX_KERNEL);
              div_cnt <= DCW'(DN - 1);
              div_use <= DU_ROW;
              state   <= S_DIV;
            end
            DU_ROW: begin
              out_slot  <= SLW'(div_rem);
              state     <= S_TAP_INIT;
            end
            default: begin
              acc[ch] <= div_neg ? -$signed(SUMW'(div_quo)) : $signed(SUMW'(div_quo));
              if (ch == 2'd2) begin
                state <= S_FINISH;
              end else begin
                ch      <= ch_sel;
                div_quo <= DN'(acc_mag);
                div_rem <= '0;
                div_den <= DD'(alpha_mag);
                div_neg <= (acc_sel < 0) ^ (alpha < 0);
                div_cnt <= DCW'(DN - 1);
                state   <= S_DIV;
              end
            end
          endcase
        end
        S_TAP_INIT: begin
          ta     <= '0;
          tb     <= '0;
          t_ci   <= CIW'(32'(k_eff) * 32'(k_eff) - 1);
          if (32'(out_slot) >= 32'(back))
            t_slot <= SLW'(32'(out_slot) - 32'(back));
          else
            t_slot <= SLW'(32'(out_slot) + MAX_KERNEL - 32'(back));
          acc[0] <= '0;
          acc[1] <= '0;
          acc[2] <= '0;
          alpha  <= '0;
          state  <= (k_eff == '0) ? S_FINISH : S_TAP;
        end
        S_TAP: begin
          tap_v    <= inb;
          tap_coef <= kernel_table[t_ci];
          t_ci     <= t_ci - 1'b1;
          if (tb == k_eff - 1'b1) begin
            tb     <= '0;
            ta     <= ta + 1'b1;
            t_slot <= (32'(t_slot) == MAX_KERNEL - 1) ? '0 : t_slot + 1'b1;
            if (ta == k_eff - 1'b1) state <= S_TAP_FLUSH;
          end else begin
            tb <= tb + 1'b1;
          end
        end
        S_TAP_FLUSH: begin
          tap_v <= 1'b0;
          state <= S_NORM;
        end
        S_NORM: begin
          if (reg_norm && alpha != '0) begin
            ch      <= 2'd0;
            div_quo <= DN'(acc_mag);
            div_rem <= '0;
            div_den <= DD'(alpha_mag);
            div_neg <= (acc_sel < 0) ^ (alpha < 0);
            div_cnt <= DCW'(DN - 1);
            div_use <= DU_CH;
            state   <= S_DIV;
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {clamp8(acc[2]), clamp8(acc[1]), clamp8(acc[0])};
            m_tlast  <= ({1'b0, out_index} + 1'b1) >= {1'b0, total};
            state    <= S_IDLE;
            if (({1'b0, out_index} + 1'b1) >= {1'b0, total}) begin
              in_col    <= '0;
              in_row    <= '0;
              in_slot   <= '0;
              out_index <= '0;
              out_col   <= '0;
              out_row   <= '0;
              out_slot  <= '0;
            end else begin
              out_index <= out_index + 1'b1;
              if (32'(out_col) + 1 >= 32'(w_eff)) begin
                out_col  <= '0;
                out_row  <= out_row + 1'b1;
                out_slot <= (32'(out_slot) == MAX_KERNEL - 1) ? '0 : out_slot + 1'b1;
              end else begin
                out_col <= out_col + 1'b1;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_we && cfg_index == REG_IMAGE_WIDTH) pos_dirty <= 1'b1;
      else if (state == S_DIV_DONE && div_use == DU_ROW) pos_dirty <= 1'b0;
    end
  end

  `RKC_CHECK_NEXT(a_busy_after_request, s_tvalid && s_tready, !s_tready, "request taken while busy")
  `RKC_CHECK(a_tap_index, state == S_TAP, 32'(t_ci) < TD, "coefficient index out of table")
  `RKC_CHECK(a_div_remainder, state == S_DIV_DONE, div_rem < div_den, "divider remainder too large")

endmodule

// ===== tb/rgb_kernel_convolution_core_tb.sv =====
// self-checking testbench for rgb_kernel_convolution_core
// predicts each output pixel from its own kernel table, line store and frame counters
// depends on rkc_pkg and the core rtl
`timescale 1ns / 100ps
module rgb_kernel_convolution_core_tb;
  import rkc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int STORE_ROWS = DEF_MAX_KERNEL;
  localparam int TAPS = DEF_MAX_KERNEL * DEF_MAX_KERNEL;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic frame_end;
  } out_pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [FUNC_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic m_tlast;

  rgb_kernel_convolution_core DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [SIZE_REG_W-1:0] width_reg;
  logic [SIZE_REG_W-1:0] height_reg;
  logic [KSIZE_REG_W-1:0] ksize_reg;
  logic norm_reg;
  int kernel_coef[TAPS];
  logic [23:0] line_rows[STORE_ROWS * DEF_MAX_WIDTH];
  int unsigned in_col, in_row, out_pos;

  out_pixel_t pending_pixels[$];
  int errors = 0;
  int items_sent = 0;
  int pixels_checked = 0;
  int frames_done = 0;
  int idle_cycles = 0;
  bit quiet = 0;

  function automatic int unsigned eff_w();
    if (width_reg == 0) return 1;
    return (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg;
  endfunction

  function automatic int unsigned eff_h();
    if (height_reg == 0) return 1;
    return (height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : height_reg;
  endfunction

  function automatic int unsigned eff_k();
    return (ksize_reg > DEF_MAX_KERNEL) ? DEF_MAX_KERNEL : ksize_reg;
  endfunction

  function automatic int unsigned reach_of(int unsigned k);
    if (k == 0) return 0;
    return (k % 2) ? k / 2 : k / 2 - 1;
  endfunction

  function automatic logic [7:0] clamp8(longint s);
    if (s > PIX_MAX) return 8'(PIX_MAX);
    if (s < 0) return 8'd0;
    return 8'(s);
  endfunction

  function automatic void convolve_pixel();
    int unsigned w, h, k, total;
    int back, fwd, ox, oy, x, y, ci;
    longint sr, sg, sb, alpha, c;
    logic [23:0] px;
    out_pixel_t o;
    w = eff_w(); h = eff_h(); k = eff_k();
    total = w * h;
    back = k / 2;
    fwd = reach_of(k);
    ox = out_pos % w;
    oy = out_pos / w;
    sr = 0; sg = 0; sb = 0; alpha = 0;
    if (k != 0) begin
      for (int i = -back; i <= fwd; i++) begin
        for (int j = -back; j <= fwd; j++) begin
          y = oy + i;
          x = ox + j;
          if (y < 0 || y >= int'(h) || x < 0 || x >= int'(w)) continue;
          ci = (k - 1 - (i + back)) * k + (k - 1 - (j + back));
          c = kernel_coef[ci];
          px = line_rows[(y % STORE_ROWS) * DEF_MAX_WIDTH + x];
          sr += longint'(px[23:16]) * c;
          sg += longint'(px[15:8]) * c;
          sb += longint'(px[7:0]) * c;
          alpha += c;
        end
      end
    end
    if (norm_reg && alpha != 0) begin
      sr = sr / alpha;
      sg = sg / alpha;
      sb = sb / alpha;
    end
    o.red = clamp8(sr);
    o.green = clamp8(sg);
    o.blue = clamp8(sb);
    o.frame_end = (out_pos + 1 >= total);
    pending_pixels.push_back(o);
    out_pos++;
    if (out_pos >= total) begin
      in_col = 0; in_row = 0; out_pos = 0;
    end
  endfunction

  function automatic void convolve_step(logic [FUNC_W-1:0] f, logic [S_TDATA_W-1:0] d);
    int unsigned w, h, n, lag;
    w = eff_w(); h = eff_h();
    case (f)
      FUNC_COEF: begin
        if (d[4:0] < TAPS) kernel_coef[d[4:0]] = int'($signed(d[12:5]));
      end
      FUNC_PIXEL: begin
        if (in_row < h) begin
          if (in_col >= w) in_col = w - 1;
          line_rows[(in_row % STORE_ROWS) * DEF_MAX_WIDTH + in_col] = {d[20:13], d[28:21], d[36:29]};
          n = in_row * w + in_col;
          in_col++;
          if (in_col >= w) begin
            in_col = 0;
            in_row++;
          end
          lag = reach_of(eff_k()) * (w + 1);
          if (out_pos < w * h && n + 1 > out_pos + lag) convolve_pixel();
        end
      end
      FUNC_DRAIN: begin
        if (in_row >= h) begin
          if (out_pos >= w * h) begin
            in_col = 0; in_row = 0; out_pos = 0;
          end else begin
            convolve_pixel();
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [S_TDATA_W-1:0] make_tdata(logic [4:0] idx, logic [7:0] cval,
      logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return {3'b000, b, g, r, cval, idx};
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [S_TDATA_W-1:0] d);
    if (!quiet && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 8)) @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser = f;
    s_tdata = d;
    do @(posedge clk); while (!s_tready);
    convolve_step(f, d);
    items_sent++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic wait_idle();
    wait (pending_pixels.size() == 0);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH: width_reg = val;
      REG_IMAGE_HEIGHT: height_reg = val;
      REG_KERNEL_SIZE: ksize_reg = val[KSIZE_REG_W-1:0];
      default: norm_reg = val[0];
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(input int w, input int h, input int k, input bit nrm);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_KERNEL_SIZE, CFG_DATA_W'(k));
    write_reg(REG_NORMALIZE, CFG_DATA_W'(nrm));
  endtask

  task automatic load_kernel(input bit positive);
    int c;
    for (int i = 0; i < TAPS; i++) begin
      c = positive ? $urandom_range(0, 9) : $urandom_range(0, 255);
      send_item(FUNC_COEF, make_tdata(5'(i), 8'(c), 8'($urandom), 8'($urandom), 8'($urandom)));
    end
  endtask

  function automatic logic [7:0] pick_chan(int mode);
    case (mode)
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // one image, with noise requests mixed in, drained until the frame ends
  task automatic run_frame(input int mode);
    int unsigned total;
    total = eff_w() * eff_h();
    for (int unsigned p = 0; p < total; p++) begin
      if ($urandom_range(0, 15) == 0)
        send_item(FUNC_DRAIN, make_tdata(5'($urandom), 8'($urandom), 8'd0, 8'd0, 8'd0));
      if ($urandom_range(0, 31) == 0)
        send_item(FUNC_UNUSED, S_TDATA_W'({$urandom, $urandom}));
      send_item(FUNC_PIXEL, make_tdata(5'($urandom), 8'($urandom),
        pick_chan(mode), pick_chan(mode), pick_chan(mode)));
    end
    if (in_row >= eff_h())
      send_item(FUNC_PIXEL, make_tdata(5'd0, 8'd0, 8'($urandom), 8'($urandom), 8'($urandom)));
    while (in_row >= eff_h())
      send_item(FUNC_DRAIN, make_tdata(5'($urandom), 8'($urandom), 8'd0, 8'd0, 8'd0));
    frames_done++;
  endtask

  task automatic test_coef_table();
    send_item(FUNC_COEF, make_tdata(5'd0, 8'h80, 8'd0, 8'd0, 8'd0));
    send_item(FUNC_COEF, make_tdata(5'd24, 8'h7f, 8'd0, 8'd0, 8'd0));
    send_item(FUNC_COEF, make_tdata(5'd25, 8'h01, 8'd0, 8'd0, 8'd0));
    send_item(FUNC_COEF, make_tdata(5'd31, 8'hff, 8'd0, 8'd0, 8'd0));
  endtask

  task automatic test_small_frames();
    configure(3, 3, 3, 0);
    load_kernel(0);
    run_frame(1);
    configure(3, 2, 3, 1);
    load_kernel(1);
    run_frame(2);
    configure(2, 2, 0, 0);
    run_frame(1);
    configure(0, 0, 7, 1);
    run_frame(0);
  endtask

  task automatic test_size_limits();
    configure(2047, 1, 2, 0);
    load_kernel(0);
    run_frame(2);
  endtask

  task automatic random_frame();
    configure($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 7),
      $urandom_range(0, 1));
    load_kernel($urandom_range(0, 1));
    run_frame($urandom_range(0, 4));
  endtask

  task automatic test_random_frames();
    while (items_sent < 1150) random_frame();
    quiet = 1;
    random_frame();
  endtask

  // result side: random stall bursts set at the falling edge
  int stall_left = 0;
  always @(negedge clk) begin
    if (quiet) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_pixel_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel %h last %b", $time, m_tdata, m_tlast);
        errors++;
      end else begin
        e = pending_pixels.pop_front();
        pixels_checked++;
        if (m_tdata[7:0] !== e.red) begin
          $display("%0t: red expected %0d actual %0d", $time, e.red, m_tdata[7:0]);
          errors++;
        end
        if (m_tdata[15:8] !== e.green) begin
          $display("%0t: green expected %0d actual %0d", $time, e.green, m_tdata[15:8]);
          errors++;
        end
        if (m_tdata[23:16] !== e.blue) begin
          $display("%0t: blue expected %0d actual %0d", $time, e.blue, m_tdata[23:16]);
          errors++;
        end
        if (m_tlast !== e.frame_end) begin
          $display("%0t: frame_end expected %b actual %b", $time, e.frame_end, m_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    width_reg = RST_IMAGE_WIDTH;
    height_reg = RST_IMAGE_HEIGHT;
    ksize_reg = RST_KERNEL_SIZE;
    norm_reg = 1'b0;
    foreach (kernel_coef[i]) kernel_coef[i] = 0;
    in_col = 0; in_row = 0; out_pos = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_coef_table();
    test_small_frames();
    test_size_limits();
    test_random_frames();
    wait (pending_pixels.size() == 0);
    repeat (200) @(posedge clk);
    $display("covered %0d requests over %0d frames, %0d output pixels checked",
      items_sent, frames_done, pixels_checked);
    $display("kernel sizes 0 to 7, both normalize modes, size saturation and ignored requests");
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
